// ===== design/slt_pkg.sv =====
package slt_pkg;

	localparam logic [2:0] CMD_SHARE      = 3'd0;
	localparam logic [2:0] CMD_UNSHARE    = 3'd1;
	localparam logic [2:0] CMD_LOCK       = 3'd2;
	localparam logic [2:0] CMD_REMOVE_ALL = 3'd3;
	localparam logic [2:0] CMD_UNLOCK     = 3'd4;

	localparam logic [2:0] MODE_MAX = 3'd4;
	localparam int unsigned ROM_DIM = 15;

	// row: requested mode*3+access-1, column: held mode*3+access-1
	localparam logic [0:14] COMPAT_ROM [ROM_DIM] = '{
		15'b111000111000000,
		15'b111111000000000,
		15'b111000000000000,
		15'b010000010000000,
		15'b010010000000000,
		15'b010000000000000,
		15'b100000100000000,
		15'b100100000000000,
		15'b100000000000000,
		15'b000000000000000,
		15'b000000000000000,
		15'b000000000000000,
		15'b000000000000111,
		15'b000000000000111,
		15'b000000000000111
	};

	function automatic logic [3:0] rom_index(input logic [2:0] mode, input logic [1:0] acc);
		return 4'(4'(mode) * 4'd3 + 4'(acc) - 4'd1);
	endfunction

	function automatic logic compat_ok(input logic [3:0] r, input logic [3:0] c);
		logic res;
		res = 1'b0;
		if (r < 4'(ROM_DIM) && c < 4'(ROM_DIM)) begin
			res = COMPAT_ROM[r][c];
		end
		return res;
	endfunction

endpackage

// ===== design/slt_ram.sv =====
module slt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/share_and_range_lock_table.sv =====
// Share-mode and byte-range lock table.
// Command channel: a request is taken at a clock edge with start high and
// busy low. busy stays high while the request walks the tables. The result
// (granted, replayed) is shown for exactly one cycle with done high; the
// receiver cannot hold it off, and busy is already low in that cycle.
// Each request runs a small sequencer over one shared scan counter:
//   owner scan
//   handle scan  (share, lock, unshare, unlock)
//   entry scan   (skipped when an unshare or
//                unlock names an unknown handle)
//   entry sweep  (remove all, matched unshare/unlock)
//   final write, then the done beat
// One table entry is read per cycle from a registered-read RAM.
// One request at a time.
// Reset clears the owner, handle and entry valid bits; the RAM contents are
// only read behind a valid bit, so no clearing pass is needed.
module share_and_range_lock_table #(
	parameter int LOCK_ENTRIES = 64,
	parameter int OWNER_SLOTS  = 32,
	parameter int HANDLE_SLOTS = 32,
	parameter int HANDLE_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [15:0] owner_id,
	input  logic [63:0] handle_w0,
	input  logic [63:0] handle_w1,
	input  logic [63:0] handle_w2,
	input  logic [63:0] handle_w3,
	input  logic [1:0]  access_kind,
	input  logic [2:0]  share_mode,
	input  logic [31:0] range_start,
	input  logic [31:0] range_length,
	input  logic [31:0] request_cookie,
	output logic        done,
	output logic        granted,
	output logic        replayed
);

	localparam int OW = $clog2(OWNER_SLOTS);
	localparam int HW = $clog2(HANDLE_SLOTS);
	localparam int EW = $clog2(LOCK_ENTRIES);
	localparam int KW = 8 * HANDLE_BYTES;
	localparam int MAXN = (LOCK_ENTRIES > OWNER_SLOTS) ?
		((LOCK_ENTRIES > HANDLE_SLOTS) ? LOCK_ENTRIES : HANDLE_SLOTS) :
		((OWNER_SLOTS > HANDLE_SLOTS) ? OWNER_SLOTS : HANDLE_SLOTS);
	localparam int CW = $clog2(MAXN + 1);
	localparam int ORW = 49;
	localparam int ERW = 1 + OW + HW + 64;

	typedef enum logic [2:0] {
		ST_IDLE, ST_OWN, ST_HND, ST_ENT, ST_SWEEP, ST_FINISH
	} state_t;

	state_t state_q;

	logic [2:0]    cmd_q;
	logic [15:0]   id_q;
	logic [KW-1:0] key_q;
	logic [1:0]    acc_q;
	logic [2:0]    mode_q;
	logic [31:0]   start_q;
	logic [31:0]   len_q;
	logic [31:0]   cookie_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_s1;
	logic          vld_s1;

	logic [OWNER_SLOTS-1:0]  owner_valid_q;
	logic [HANDLE_SLOTS-1:0] handle_valid_q;
	logic [LOCK_ENTRIES-1:0] entry_valid_q;
	logic [HANDLE_SLOTS-1:0] used_q;
	logic                    ownused_q;

	logic          own_hit_q, own_free_q, own_res_q;
	logic [OW-1:0] own_idx_q, own_free_idx_q;
	logic [31:0]   own_cookie_q;
	logic          hnd_hit_q, hnd_free_q;
	logic [HW-1:0] hnd_idx_q, hnd_free_idx_q;
	logic          ok_q, ent_free_q, match_q, ins_q, newh_q, res_q;
	logic [EW-1:0] ent_free_idx_q, match_idx_q;

	logic          done_q, granted_q, replayed_q;

	logic [ORW-1:0] own_rd;
	logic [KW-1:0]  hnd_rd;
	logic [ERW-1:0] ent_rd;

	logic [CW-1:0] lim;
	logic          scan_done;
	logic [OW-1:0] oi;
	logic [HW-1:0] hi;
	logic [EW-1:0] ei;
	logic          is_lock, is_ins, is_known;
	logic [63:0]   want;
	logic [63:0]   e_body;
	logic [HW-1:0] e_hnd;
	logic [OW-1:0] e_own;
	logic          e_kind, ev;
	logic [32:0]   new_end, old_end;
	logic          overlap, conflict;
	logic          fin;
	logic [255:0]  hw_all;

	assign hw_all = {handle_w3, handle_w2, handle_w1, handle_w0};

	always_comb begin
		case (state_q)
			ST_OWN:  lim = CW'(OWNER_SLOTS);
			ST_HND:  lim = CW'(HANDLE_SLOTS);
			default: lim = CW'(LOCK_ENTRIES);
		endcase
	end

	assign scan_done = (cnt_q == lim) && !vld_s1;
	assign oi = idx_s1[OW-1:0];
	assign hi = idx_s1[HW-1:0];
	assign ei = idx_s1[EW-1:0];

	assign is_lock  = (cmd_q == slt_pkg::CMD_LOCK) || (cmd_q == slt_pkg::CMD_UNLOCK);
	assign is_ins   = (cmd_q == slt_pkg::CMD_SHARE) || (cmd_q == slt_pkg::CMD_LOCK);
	assign is_known = is_ins || (cmd_q == slt_pkg::CMD_UNSHARE) ||
		(cmd_q == slt_pkg::CMD_UNLOCK);
	assign want = is_lock ? {start_q, len_q} : {59'd0, mode_q, acc_q};

	assign e_body = ent_rd[63:0];
	assign e_hnd  = ent_rd[64 +: HW];
	assign e_own  = ent_rd[64 + HW +: OW];
	assign e_kind = ent_rd[64 + HW + OW];
	assign ev     = entry_valid_q[ei];

	// sums kept at 33 bits so a range near the top never wraps
	assign new_end = {1'b0, start_q} + {1'b0, len_q};
	assign old_end = {1'b0, e_body[63:32]} + {1'b0, e_body[31:0]};
	assign overlap = (e_body[63:32] >= start_q && new_end > {1'b0, e_body[63:32]}) ||
		(e_body[63:32] < start_q && old_end > {1'b0, start_q});
	assign conflict = is_lock ? overlap :
		!slt_pkg::compat_ok(slt_pkg::rom_index(mode_q, acc_q),
			slt_pkg::rom_index(e_body[4:2], e_body[1:0]));

	assign fin = (state_q == ST_FINISH);

	slt_ram #(.WIDTH(ORW), .DEPTH(OWNER_SLOTS)) u_own_ram (
		.clk   (clk),
		.we    (fin),
		.waddr (own_idx_q),
		.wdata ({res_q, cookie_q, id_q}),
		.raddr (cnt_q[OW-1:0]),
		.rdata (own_rd)
	);

	slt_ram #(.WIDTH(KW), .DEPTH(HANDLE_SLOTS)) u_hnd_ram (
		.clk   (clk),
		.we    (fin && ins_q && newh_q),
		.waddr (hnd_free_idx_q),
		.wdata (key_q),
		.raddr (cnt_q[HW-1:0]),
		.rdata (hnd_rd)
	);

	slt_ram #(.WIDTH(ERW), .DEPTH(LOCK_ENTRIES)) u_ent_ram (
		.clk   (clk),
		.we    (fin && ins_q),
		.waddr (ent_free_idx_q),
		.wdata ({is_lock, own_idx_q, (newh_q ? hnd_free_idx_q : hnd_idx_q), want}),
		.raddr (cnt_q[EW-1:0]),
		.rdata (ent_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cmd_q          <= '0;
			id_q           <= '0;
			key_q          <= '0;
			acc_q          <= '0;
			mode_q         <= '0;
			start_q        <= '0;
			len_q          <= '0;
			cookie_q       <= '0;
			cnt_q          <= '0;
			idx_s1         <= '0;
			vld_s1         <= 1'b0;
			owner_valid_q  <= '0;
			handle_valid_q <= '0;
			entry_valid_q  <= '0;
			used_q         <= '0;
			ownused_q      <= 1'b0;
			own_hit_q      <= 1'b0;
			own_free_q     <= 1'b0;
			own_res_q      <= 1'b0;
			own_idx_q      <= '0;
			own_free_idx_q <= '0;
			own_cookie_q   <= '0;
			hnd_hit_q      <= 1'b0;
			hnd_free_q     <= 1'b0;
			hnd_idx_q      <= '0;
			hnd_free_idx_q <= '0;
			ok_q           <= 1'b0;
			ent_free_q     <= 1'b0;
			match_q        <= 1'b0;
			ins_q          <= 1'b0;
			newh_q         <= 1'b0;
			res_q          <= 1'b0;
			ent_free_idx_q <= '0;
			match_idx_q    <= '0;
			done_q         <= 1'b0;
			granted_q      <= 1'b0;
			replayed_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q != ST_IDLE && state_q != ST_FINISH) begin
				if (cnt_q != lim) begin
					cnt_q  <= cnt_q + 1'b1;
					idx_s1 <= cnt_q;
					vld_s1 <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q      <= cmd;
						id_q       <= owner_id;
						key_q      <= hw_all[KW-1:0];
						acc_q      <= access_kind;
						mode_q     <= share_mode;
						start_q    <= range_start;
						len_q      <= range_length;
						cookie_q   <= request_cookie;
						cnt_q      <= '0;
						vld_s1     <= 1'b0;
						own_hit_q  <= 1'b0;
						own_free_q <= 1'b0;
						ins_q      <= 1'b0;
						state_q    <= ST_OWN;
					end
				end
				ST_OWN: begin
					if (vld_s1) begin
						if (owner_valid_q[oi] && own_rd[15:0] == id_q && !own_hit_q) begin
							own_hit_q    <= 1'b1;
							own_idx_q    <= oi;
							own_cookie_q <= own_rd[47:16];
							own_res_q    <= own_rd[48];
						end
						if (!owner_valid_q[oi] && !own_free_q) begin
							own_free_q     <= 1'b1;
							own_free_idx_q <= oi;
						end
					end
					if (scan_done) begin
						cnt_q      <= '0;
						hnd_hit_q  <= 1'b0;
						hnd_free_q <= 1'b0;
						ent_free_q <= 1'b0;
						match_q    <= 1'b0;
						used_q     <= '0;
						ownused_q  <= 1'b0;
						res_q      <= 1'b0;
						ok_q <= !(cmd_q == slt_pkg::CMD_SHARE &&
							(mode_q > slt_pkg::MODE_MAX || acc_q == 2'd0));
						if (cmd_q == slt_pkg::CMD_REMOVE_ALL) begin
							if (own_hit_q) begin
								state_q <= ST_SWEEP;
							end else begin
								granted_q  <= 1'b1;
								replayed_q <= 1'b0;
								done_q     <= 1'b1;
								state_q    <= ST_IDLE;
							end
						end else if (own_hit_q && own_cookie_q == cookie_q) begin
							granted_q  <= own_res_q;
							replayed_q <= 1'b1;
							done_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end else if (!own_hit_q && !own_free_q) begin
							granted_q  <= 1'b0;
							replayed_q <= 1'b0;
							done_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							if (!own_hit_q) begin
								own_idx_q <= own_free_idx_q;
							end
							state_q <= is_known ? ST_HND : ST_FINISH;
						end
					end
				end
				ST_HND: begin
					if (vld_s1) begin
						if (handle_valid_q[hi] && hnd_rd == key_q && !hnd_hit_q) begin
							hnd_hit_q <= 1'b1;
							hnd_idx_q <= hi;
						end
						if (!handle_valid_q[hi] && !hnd_free_q) begin
							hnd_free_q     <= 1'b1;
							hnd_free_idx_q <= hi;
						end
					end
					if (scan_done) begin
						cnt_q <= '0;
						if (is_ins || hnd_hit_q) begin
							state_q <= ST_ENT;
						end else begin
							res_q   <= 1'b1;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_ENT: begin
					if (vld_s1) begin
						if (is_ins) begin
							if (ev && hnd_hit_q && e_hnd == hnd_idx_q && e_kind == is_lock &&
								conflict) begin
								ok_q <= 1'b0;
							end
							if (!ev && !ent_free_q) begin
								ent_free_q     <= 1'b1;
								ent_free_idx_q <= ei;
							end
						end else if (!match_q && ev && e_hnd == hnd_idx_q &&
							e_own == own_idx_q && e_kind == is_lock && e_body == want) begin
							match_q     <= 1'b1;
							match_idx_q <= ei;
						end
					end
					if (scan_done) begin
						cnt_q <= '0;
						if (is_ins) begin
							ins_q   <= ok_q && ent_free_q && (hnd_hit_q || hnd_free_q);
							res_q   <= ok_q && ent_free_q && (hnd_hit_q || hnd_free_q);
							newh_q  <= !hnd_hit_q;
							state_q <= ST_FINISH;
						end else if (match_q) begin
							state_q <= ST_SWEEP;
						end else begin
							res_q   <= 1'b1;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SWEEP: begin
					// drop the chosen entries, note which handles and whether the owner
					// still hold anything
					if (vld_s1 && ev) begin
						if ((cmd_q == slt_pkg::CMD_REMOVE_ALL) ? (e_own == own_idx_q) :
							(ei == match_idx_q)) begin
							entry_valid_q[ei] <= 1'b0;
						end else begin
							used_q[e_hnd] <= 1'b1;
							if (e_own == own_idx_q) begin
								ownused_q <= 1'b1;
							end
						end
					end
					if (scan_done) begin
						cnt_q          <= '0;
						handle_valid_q <= handle_valid_q & used_q;
						if (cmd_q == slt_pkg::CMD_REMOVE_ALL || !ownused_q) begin
							owner_valid_q[own_idx_q] <= 1'b0;
							granted_q  <= 1'b1;
							replayed_q <= 1'b0;
							done_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							res_q   <= 1'b1;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					owner_valid_q[own_idx_q] <= 1'b1;
					if (ins_q) begin
						entry_valid_q[ent_free_idx_q] <= 1'b1;
						if (newh_q) begin
							handle_valid_q[hnd_free_idx_q] <= 1'b1;
						end
					end
					granted_q  <= res_q;
					replayed_q <= 1'b0;
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign granted  = granted_q;
	assign replayed = replayed_q;

endmodule

// ===== verif/tb_share_and_range_lock_table.sv =====
module tb_share_and_range_lock_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENT = 64;
	localparam int N_OWN = 32;
	localparam int N_HND = 32;
	localparam logic [2:0] CMD_UNKNOWN  = 3'd5;
	localparam logic [2:0] CMD_RESERVED = 3'd7;

	typedef struct {
		logic [2:0]  cmd;
		logic [15:0] id;
		logic [63:0] hw [4];
		logic [1:0]  acc;
		logic [2:0]  mode;
		logic [31:0] rs;
		logic [31:0] rl;
		logic [31:0] ck;
	} req_t;

	class lock_scoreboard;
		bit        own_v [N_OWN];
		bit [15:0] own_key [N_OWN];
		bit [31:0] own_ck [N_OWN];
		bit        own_res [N_OWN];
		bit        hnd_v [N_HND];
		bit [63:0] hnd_w [N_HND][4];
		bit        ent_v [N_ENT];
		bit        ent_rng [N_ENT];
		bit [63:0] ent_body [N_ENT];
		int        ent_own [N_ENT];
		int        ent_hnd [N_ENT];
		bit        exp_g [$];
		bit        exp_r [$];
		int        errors;
		int        n_req, n_grant, n_replay;

		function int find_owner(bit [15:0] id);
			for (int i = 0; i < N_OWN; i++)
				if (own_v[i] && own_key[i] == id) return i;
			return -1;
		endfunction

		function int find_handle(req_t q);
			bit same;
			for (int i = 0; i < N_HND; i++) begin
				same = hnd_v[i];
				for (int w = 0; w < 4; w++)
					if (hnd_w[i][w] != q.hw[w]) same = 0;
				if (same) return i;
			end
			return -1;
		endfunction

		function bit owner_used(int o);
			for (int e = 0; e < N_ENT; e++)
				if (ent_v[e] && ent_own[e] == o) return 1;
			return 0;
		endfunction

		function void drop_entry(int e);
			int h;
			h = ent_hnd[e];
			ent_v[e] = 0;
			for (int k = 0; k < N_ENT; k++)
				if (ent_v[k] && ent_hnd[k] == h) return;
			hnd_v[h] = 0;
		endfunction

		function void push(bit g, bit r);
			exp_g.push_back(g);
			exp_r.push_back(r);
		endfunction

		function int pending();
			return exp_g.size();
		endfunction

		function void note(req_t q);
			int o, h, e;
			bit ok, res, lk, conflict;
			bit [63:0] want, s, l, es, el;
			n_req++;
			s = 64'(q.rs);
			l = 64'(q.rl);
			o = find_owner(q.id);
			if (q.cmd == slt_pkg::CMD_REMOVE_ALL) begin
				if (o >= 0) begin
					for (e = 0; e < N_ENT; e++)
						if (ent_v[e] && ent_own[e] == o) drop_entry(e);
					own_v[o] = 0;
				end
				push(1'b1, 1'b0);
				return;
			end
			if (o < 0) begin
				o = 0;
				while (o < N_OWN && own_v[o]) o++;
				if (o >= N_OWN) begin
					push(1'b0, 1'b0);
					return;
				end
				own_v[o] = 1;
				own_key[o] = q.id;
			end else if (own_ck[o] == q.ck) begin
				push(own_res[o], 1'b1);
				return;
			end
			own_ck[o] = q.ck;
			res = 0;
			if (q.cmd == slt_pkg::CMD_SHARE || q.cmd == slt_pkg::CMD_LOCK) begin
				lk = (q.cmd == slt_pkg::CMD_LOCK);
				ok = 1;
				if (!lk && (q.mode > slt_pkg::MODE_MAX || q.acc == 2'd0)) ok = 0;
				h = find_handle(q);
				if (ok && h >= 0) begin
					for (e = 0; e < N_ENT; e++) begin
						if (!ent_v[e] || ent_hnd[e] != h || ent_rng[e] != lk) continue;
						if (lk) begin
							es = ent_body[e] >> 32;
							el = {32'd0, ent_body[e][31:0]};
							conflict = (es >= s && s + l > es) || (es < s && es + el > s);
						end else begin
							conflict = !slt_pkg::COMPAT_ROM[int'(q.mode) * 3 + int'(q.acc) - 1]
								[int'(ent_body[e][4:2]) * 3 + int'(ent_body[e][1:0]) - 1];
						end
						if (conflict) ok = 0;
					end
				end
				e = -1;
				if (ok) begin
					for (int k = N_ENT - 1; k >= 0; k--)
						if (!ent_v[k]) e = k;
				end
				if (e < 0) ok = 0;
				if (ok && h < 0) begin
					h = 0;
					while (h < N_HND && hnd_v[h]) h++;
					if (h >= N_HND) ok = 0;
					else begin
						hnd_v[h] = 1;
						for (int w = 0; w < 4; w++) hnd_w[h][w] = q.hw[w];
					end
				end
				if (ok) begin
					ent_v[e] = 1;
					ent_rng[e] = lk;
					ent_own[e] = o;
					ent_hnd[e] = h;
					ent_body[e] = lk ? {q.rs, q.rl} : 64'({q.mode, q.acc});
					res = 1;
				end
			end else if (q.cmd == slt_pkg::CMD_UNSHARE || q.cmd == slt_pkg::CMD_UNLOCK) begin
				lk = (q.cmd == slt_pkg::CMD_UNLOCK);
				want = lk ? {q.rs, q.rl} : 64'({q.mode, q.acc});
				h = find_handle(q);
				res = 1;
				if (h >= 0) begin
					for (e = 0; e < N_ENT; e++) begin
						if (ent_v[e] && ent_hnd[e] == h && ent_own[e] == o &&
							ent_rng[e] == lk && ent_body[e] == want) begin
							drop_entry(e);
							// owner with nothing left goes away, cookie too
							if (!owner_used(o)) begin
								own_v[o] = 0;
								push(1'b1, 1'b0);
								return;
							end
							break;
						end
					end
				end
			end
			own_res[o] = res;
			push(res, 1'b0);
		endfunction

		function void check(bit g, bit r);
			bit eg, er;
			if (exp_g.size() == 0) begin
				$display("%0t: unexpected result granted=%0b replayed=%0b", $time, g, r);
				errors++;
				return;
			end
			eg = exp_g.pop_front();
			er = exp_r.pop_front();
			if (g) n_grant++;
			if (r) n_replay++;
			if (g !== eg) begin
				$display("%0t: granted mismatch exp=%0b act=%0b", $time, eg, g);
				errors++;
			end
			if (r !== er) begin
				$display("%0t: replayed mismatch exp=%0b act=%0b", $time, er, r);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [15:0] owner_id;
	logic [63:0] handle_w0, handle_w1, handle_w2, handle_w3;
	logic [1:0]  access_kind;
	logic [2:0]  share_mode;
	logic [31:0] range_start, range_length, request_cookie;
	logic        done, granted, replayed;

	lock_scoreboard sb = new();
	bit [31:0] cookie_of [bit [15:0]];
	int idle_pct;

	share_and_range_lock_table i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .owner_id(owner_id),
		.handle_w0(handle_w0), .handle_w1(handle_w1),
		.handle_w2(handle_w2), .handle_w3(handle_w3),
		.access_kind(access_kind), .share_mode(share_mode),
		.range_start(range_start), .range_length(range_length),
		.request_cookie(request_cookie),
		.done(done), .granted(granted), .replayed(replayed)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		req_t q;
		if (arst_n) begin
			if (done) sb.check(granted, replayed);
			if (start && !busy) begin
				q.cmd = cmd;
				q.id = owner_id;
				q.hw[0] = handle_w0;
				q.hw[1] = handle_w1;
				q.hw[2] = handle_w2;
				q.hw[3] = handle_w3;
				q.acc = access_kind;
				q.mode = share_mode;
				q.rs = range_start;
				q.rl = range_length;
				q.ck = request_cookie;
				sb.note(q);
			end
		end
	end

	// one beat; afterwards start drops only if a gap or a drain follows
	task automatic send(logic [2:0] c, logic [15:0] id, logic [63:0] h0, logic [63:0] h1,
		logic [63:0] h2, logic [63:0] h3, logic [1:0] a, logic [2:0] m,
		logic [31:0] rs, logic [31:0] rl, logic [31:0] ck, bit drain);
		int gap;
		start <= 1;
		cmd <= c;
		owner_id <= id;
		handle_w0 <= h0;
		handle_w1 <= h1;
		handle_w2 <= h2;
		handle_w3 <= h3;
		access_kind <= a;
		share_mode <= m;
		range_start <= rs;
		range_length <= rl;
		request_cookie <= ck;
		do @(posedge clk); while (busy);
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0 || drain) begin
			start <= 0;
			repeat (gap) @(posedge clk);
			if (drain) while (sb.pending() > 0) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] hword(int h, int w);
		return (64'(h + 1) * 64'h9E37_79B9_7F4A_7C15) ^ (64'(w) << 61) ^ 64'(w * 3);
	endfunction

	task automatic rand_item(bit drain);
		int sel, hsel;
		logic [2:0] c;
		logic [15:0] id;
		logic [63:0] hw [4];
		logic [31:0] rs, rl, ck;
		sel = $urandom_range(99);
		if (sel < 30) c = slt_pkg::CMD_SHARE;
		else if (sel < 60) c = slt_pkg::CMD_LOCK;
		else if (sel < 72) c = slt_pkg::CMD_UNSHARE;
		else if (sel < 84) c = slt_pkg::CMD_UNLOCK;
		else if (sel < 92) c = slt_pkg::CMD_REMOVE_ALL;
		else c = 3'($urandom_range(CMD_UNKNOWN, CMD_RESERVED));
		if ($urandom_range(19) == 0) id = 16'($urandom);
		else id = 16'($urandom_range(0, 39) * 1237 + 5);
		hsel = $urandom_range(0, 7);
		for (int w = 0; w < 4; w++)
			hw[w] = ($urandom_range(19) == 0) ? {$urandom, $urandom} : hword(hsel, w);
		if ($urandom_range(6) == 0) begin
			rs = $urandom;
			rl = $urandom;
		end else begin
			rs = $urandom_range(0, 15) * 8;
			rl = $urandom_range(1) ? 32'd8 : 32'($urandom_range(0, 24));
		end
		if (!cookie_of.exists(id)) cookie_of[id] = $urandom;
		else if ($urandom_range(9) != 0) cookie_of[id] = cookie_of[id] + 1;
		ck = cookie_of[id];
		send(c, id, hw[0], hw[1], hw[2], hw[3], 2'($urandom),
			($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
			rs, rl, ck, drain);
	endtask

	initial begin
		logic [63:0] a0, a1, a2, a3;
		arst_n = 0;
		start = 0;
		cmd = '0;
		owner_id = '0;
		handle_w0 = '0;
		handle_w1 = '0;
		handle_w2 = '0;
		handle_w3 = '0;
		access_kind = '0;
		share_mode = '0;
		range_start = '0;
		range_length = '0;
		request_cookie = '0;
		idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		a0 = hword(0, 0); a1 = hword(0, 1); a2 = hword(0, 2); a3 = hword(0, 3);
		// directed: unknown owner remove, shares of each mode, invalid shares
		send(slt_pkg::CMD_REMOVE_ALL, 16'hFFFF, a0, a1, a2, a3, 2'd1, 3'd0, 32'd0, 32'd0,
			32'd0, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd1, a0, a1, a2, a3, 2'd3, 3'd0, 32'd0, 32'd0,
			32'd10, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd1, a0, a1, a2, a3, 2'd3, 3'd0, 32'd0, 32'd0,
			32'd10, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd2, a0, a1, a2, a3, 2'd1, 3'd1, 32'd0, 32'd0,
			32'd20, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd3, a0, a1, a2, a3, 2'd2, 3'd2, 32'd0, 32'd0,
			32'd30, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd4, a0, a1, a2, a3, 2'd3, 3'd3, 32'd0, 32'd0,
			32'd40, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd5, a0, a1, a2, a3, 2'd1, 3'd4, 32'd0, 32'd0,
			32'd50, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd6, ~a0, a1, a2, a3, 2'd0, 3'd0, 32'd0, 32'd0,
			32'd60, 1'b0);
		send(slt_pkg::CMD_SHARE, 16'd6, ~a0, a1, a2, a3, 2'd1, 3'd7, 32'd0, 32'd0,
			32'd61, 1'b0);
		// ranges: full extent, overlap, wrap-free sums, unlock; then unshares, unknown commands, remove all
		send(slt_pkg::CMD_LOCK, 16'd7, a0, a1, a2, a3, 2'd0, 3'd0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send(slt_pkg::CMD_LOCK, 16'd8, a0, a1, a2, a3, 2'd0, 3'd0, 32'h0, 32'hFFFF_FFFF,
			32'd1, 1'b0);
		send(slt_pkg::CMD_LOCK, 16'd9, a0, a1, a2, a3, 2'd0, 3'd0, 32'h0, 32'd0,
			32'd2, 1'b0);
		send(slt_pkg::CMD_LOCK, 16'd9, a0, a1, a2, a3, 2'd0, 3'd0, 32'h100, 32'd16,
			32'd3, 1'b0);
		send(slt_pkg::CMD_UNLOCK, 16'd9, a0, a1, a2, a3, 2'd0, 3'd0, 32'h100, 32'd16,
			32'd4, 1'b0);
		send(slt_pkg::CMD_UNLOCK, 16'd9, a0, a1, a2, a3, 2'd0, 3'd0, 32'h200, 32'd16,
			32'd5, 1'b0);
		send(slt_pkg::CMD_UNSHARE, 16'd2, a0, a1, a2, a3, 2'd1, 3'd1, 32'd0, 32'd0,
			32'd21, 1'b0);
		send(slt_pkg::CMD_UNSHARE, 16'd1, ~a0, ~a1, ~a2, ~a3, 2'd3, 3'd0, 32'd0, 32'd0,
			32'd11, 1'b0);
		send(CMD_UNKNOWN, 16'd10, a0, a1, a2, a3, 2'd0, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send(CMD_RESERVED, 16'd10, a0, a1, a2, a3, 2'd0, 3'd0, 32'd0, 32'd0, 32'd1, 1'b0);
		send(CMD_RESERVED, 16'd10, a0, a1, a2, a3, 2'd0, 3'd0, 32'd0, 32'd0, 32'd1, 1'b0);
		send(slt_pkg::CMD_REMOVE_ALL, 16'd1, a0, a1, a2, a3, 2'd0, 3'd0, 32'd0, 32'd0,
			32'd0, 1'b0);
		// owner table overflow
		for (int i = 0; i < 34; i++)
			send(CMD_UNKNOWN, 16'(16'h8000 + i), a0, a1, a2, a3, 2'd0, 3'd0, 32'd0, 32'd0,
				32'd0, 1'b0);
		for (int i = 0; i < 34; i++)
			send(slt_pkg::CMD_REMOVE_ALL, 16'(16'h8000 + i), a0, a1, a2, a3, 2'd0, 3'd0,
				32'd0, 32'd0, 32'd0, i == 33);

		for (int n = 0; n < 560; n++) begin
			case (n * 4 / 560)
				0: idle_pct = 0;
				1: idle_pct = 58;
				2: idle_pct = 58;
				default: idle_pct = 35;
			endcase
			rand_item(n == 300);
		end
		start <= 0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d requests: shares, ranges, removals, unknown commands.",
			sb.n_req);
		$display("Results seen: %0d granted, %0d replayed.", sb.n_grant, sb.n_replay);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
